[src/delayed_event_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// Delayed event queue assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef DELAYED_EVENT_QUEUE_TOP_DEFINES_SVH
`define DELAYED_EVENT_QUEUE_TOP_DEFINES_SVH

// condition holds at every edge
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DEQ_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// Delayed event queue package
// Field widths, function and result codes, entry layout and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;

	localparam int FUNC_W  = 3;
	localparam int TGT_W   = 8;
	localparam int TYPE_W  = 16;
	localparam int HND_W   = 32;
	localparam int DELAY_W = 32;
	localparam int TIME_W  = 48;
	localparam int KIND_W  = 2;
	localparam int RCNT_W  = 5;
	localparam int KD_W    = $clog2(MAX_RESULTS + 1);
	localparam int ENTRY_W = TIME_W + TGT_W + TYPE_W + HND_W;

	localparam int RCNT_MAX = (1 << RCNT_W) - 1;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum logic [FUNC_W-1:0] {
		FN_POST     = 3'd0,
		FN_DEBOUNCE = 3'd1,
		FN_REMOVE   = 3'd2,
		FN_CONTAINS = 3'd3,
		FN_TICK     = 3'd4
	} func_t;

	localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POST     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CONTAINS = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [TGT_W-1:0]  target;
		logic [TYPE_W-1:0] mtype;
		logic [HND_W-1:0]  handle;
	} entry_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic run_cmp;
		logic run_ins;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic cmp_done;
		logic ins_done;
	} dp_status_t;

endpackage

[src/deq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// Delayed event queue controller
// Sequences each accepted word through the compaction walk, the insert walk
// or both, and then the result cycle; unknown function codes stay idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [deq_pkg::FUNC_W-1:0] func,
	input  deq_pkg::dp_status_t        status,
	output deq_pkg::dp_cmd_t           cmd,
	output logic                       busy
);

	import deq_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CMP  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_INS  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	func_t  op_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(func))
						FN_POST:     state_d = ST_PREP;
						FN_DEBOUNCE: state_d = ST_CMP;
						FN_REMOVE:   state_d = ST_CMP;
						FN_CONTAINS: state_d = ST_CMP;
						FN_TICK:     state_d = ST_CMP;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CMP: begin
				if (status.cmp_done) begin
					state_d = (op_q == FN_DEBOUNCE) ? ST_PREP : ST_FIN;
				end
			end
			ST_PREP: state_d = ST_INS;
			ST_INS: begin
				if (status.ins_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= FN_POST;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= func_t'(func);
			end
		end
	end

	assign cmd.load    = accept;
	assign cmd.prep    = (state_q == ST_PREP);
	assign cmd.run_cmp = (state_q == ST_CMP);
	assign cmd.run_ins = (state_q == ST_INS);
	assign cmd.fin     = (state_q == ST_FIN);
	assign busy        = (state_q != ST_IDLE);

endmodule

[src/deq_datapath.sv]
// ----------------------------------------------------------------------------
// Delayed event queue datapath
// Entry RAM, millisecond clock, walk pointers, match and due-time compares,
// pending dispatch word and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "delayed_event_queue_top_defines.svh"

module deq_datapath #(
	parameter int QUEUE_DEPTH = deq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  deq_pkg::dp_cmd_t                   cmd,
	output deq_pkg::dp_status_t                status,
	input  logic [deq_pkg::FUNC_W-1:0]         func,
	input  logic [deq_pkg::TGT_W-1:0]          target_id,
	input  logic [deq_pkg::TYPE_W-1:0]         msg_type,
	input  logic                               any_type,
	input  logic [deq_pkg::HND_W-1:0]          message_handle,
	input  logic signed [deq_pkg::DELAY_W-1:0] delay_ms,
	output logic                               valid,
	output logic [deq_pkg::KIND_W-1:0]         kind,
	output logic [deq_pkg::TGT_W-1:0]          out_target,
	output logic [deq_pkg::TYPE_W-1:0]         out_type,
	output logic [deq_pkg::HND_W-1:0]          out_handle,
	output logic [deq_pkg::RCNT_W-1:0]         removed_count,
	output logic                               found,
	output logic                               rejected_full,
	output logic                               new_head,
	output logic                               last
);

	import deq_pkg::*;

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int RM_W   = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;

	// held word and state
	func_t             op_q;
	logic [TGT_W-1:0]  tgt_q;
	logic [TYPE_W-1:0] typ_q;
	logic              any_q;
	logic [HND_W-1:0]  hnd_q;
	logic [TIME_W-1:0] due_q;
	logic [TIME_W-1:0] clock_q;
	logic [CNT_W-1:0]  count_q;

	// walk state
	logic [CNT_W-1:0]  rd_q;
	logic [CNT_W-1:0]  wr_q;
	logic              rvalid_s1;
	logic [RM_W-1:0]   removed_q;
	logic              found_q;
	logic              stop_q;
	logic [KD_W-1:0]   kdisp_q;
	logic              pend_valid_q;
	entry_t            pend_q;
	logic              rejected_q;
	logic              new_head_q;

	// result register
	logic              valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [TGT_W-1:0]  out_target_q;
	logic [TYPE_W-1:0] out_type_q;
	logic [HND_W-1:0]  out_handle_q;
	logic [RCNT_W-1:0] removed_count_q;
	logic              found_res_q;
	logic              rejected_full_q;
	logic              new_head_res_q;
	logic              last_q;

	// RAM port
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t            rd_e;
	entry_t            new_e;
	logic [TIME_W:0]   delay_ext;
	logic [TIME_W:0]   due_sum;
	logic [TIME_W-1:0] due_new;
	logic [CNT_W-1:0]  rd_dec;
	logic              full;
	logic              any_eff;
	logic              match;
	logic              disp;
	logic              drop;
	logic              cmp_issue;
	logic              cmp_proc;
	logic              cmp_write;
	logic              ins_issue;
	logic              later;
	logic              ins_shift;
	logic              ins_place;
	logic              emit_walk;
	logic              emit_fin;
	logic [RCNT_W-1:0] removed_sat;

	assign rd_e  = entry_t'(ram_rdata);
	assign new_e = '{due: due_q, target: tgt_q, mtype: typ_q, handle: hnd_q};

	// clamp delay, add, saturate
	assign delay_ext = delay_ms[DELAY_W-1] ? '0
		: {{(TIME_W + 2 - DELAY_W){1'b0}}, delay_ms[DELAY_W-2:0]};
	assign due_sum   = {1'b0, clock_q} + delay_ext;
	assign due_new   = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];

	assign rd_dec  = rd_q - CNT_W'(1);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign any_eff = any_q && (op_q != FN_DEBOUNCE);
	assign match   = (rd_e.target == tgt_q) && (any_eff || (rd_e.mtype == typ_q));
	assign disp    = (op_q == FN_TICK) && !stop_q && (kdisp_q < KD_W'(MAX_RESULTS))
		&& (rd_e.due <= clock_q);

	always_comb begin
		case (op_q)
			FN_REMOVE:   drop = match;
			FN_DEBOUNCE: drop = match;
			FN_TICK:     drop = disp;
			default:     drop = 1'b0;
		endcase
	end

	// compaction walk
	assign cmp_issue = cmd.run_cmp && (rd_q < count_q);
	assign cmp_proc  = cmd.run_cmp && rvalid_s1;
	assign cmp_write = cmp_proc && !drop && (op_q != FN_CONTAINS);

	// insert walk, from the tail down
	assign later     = rd_e.due > due_q;
	assign ins_issue = cmd.run_ins && !full && (rd_q != '0);
	assign ins_shift = cmd.run_ins && rvalid_s1 && later;
	assign ins_place = cmd.run_ins && !full
		&& ((rvalid_s1 && !later) || (!rvalid_s1 && (rd_q == '0)));

	assign status.cmp_done = cmd.run_cmp && !rvalid_s1 && (rd_q == count_q);
	assign status.ins_done = cmd.run_ins && (full || ins_place);

	assign ram_we    = cmp_write || ins_shift || ins_place;
	assign ram_re    = cmp_issue || ins_issue;
	assign ram_waddr = wr_q[ADDR_W-1:0];
	assign ram_raddr = cmd.run_ins ? rd_dec[ADDR_W-1:0] : rd_q[ADDR_W-1:0];
	assign ram_wdata = ins_place ? ENTRY_W'(new_e) : ram_rdata;

	deq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign emit_walk   = cmp_proc && (op_q == FN_TICK) && pend_valid_q;
	assign emit_fin    = cmd.fin && ((op_q != FN_TICK) || pend_valid_q);
	assign removed_sat = (removed_q > RM_W'(RCNT_MAX)) ? RCNT_W'(RCNT_MAX)
		: removed_q[RCNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= FN_POST;
			clock_q      <= '0;
			count_q      <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			rvalid_s1    <= 1'b0;
			removed_q    <= '0;
			found_q      <= 1'b0;
			stop_q       <= 1'b0;
			kdisp_q      <= '0;
			pend_valid_q <= 1'b0;
			rejected_q   <= 1'b0;
			new_head_q   <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			valid_q <= emit_walk || emit_fin;
			if (cmd.load) begin
				op_q         <= func_t'(func);
				rd_q         <= '0;
				wr_q         <= '0;
				rvalid_s1    <= 1'b0;
				removed_q    <= '0;
				found_q      <= 1'b0;
				stop_q       <= 1'b0;
				kdisp_q      <= '0;
				pend_valid_q <= 1'b0;
				rejected_q   <= 1'b0;
				new_head_q   <= 1'b0;
				if ((func_t'(func) == FN_TICK) && (clock_q != TIME_MAX)) begin
					clock_q <= clock_q + TIME_W'(1);
				end
			end
			if (cmd.prep) begin
				rd_q      <= count_q;
				wr_q      <= count_q;
				rvalid_s1 <= 1'b0;
			end
			if (cmd.run_cmp) begin
				rvalid_s1 <= cmp_issue;
				if (cmp_issue) begin
					rd_q <= rd_q + CNT_W'(1);
				end
				if (cmp_proc && !drop) begin
					wr_q <= wr_q + CNT_W'(1);
				end
				if (cmp_proc && drop && (op_q != FN_TICK)) begin
					removed_q <= removed_q + RM_W'(1);
				end
				if (cmp_proc && match && (op_q == FN_CONTAINS)) begin
					found_q <= 1'b1;
				end
				if (cmp_proc && (op_q == FN_TICK)) begin
					if (disp) begin
						kdisp_q      <= kdisp_q + KD_W'(1);
						pend_valid_q <= 1'b1;
					end else begin
						stop_q       <= 1'b1;
						pend_valid_q <= 1'b0;
					end
				end
				if (status.cmp_done) begin
					count_q <= wr_q;
				end
			end
			if (cmd.run_ins) begin
				rvalid_s1 <= ins_issue;
				if (ins_issue) begin
					rd_q <= rd_dec;
				end
				if (ins_shift) begin
					wr_q <= wr_q - CNT_W'(1);
				end
				if (status.ins_done) begin
					if (full) begin
						rejected_q <= 1'b1;
					end else begin
						count_q    <= count_q + CNT_W'(1);
						new_head_q <= (wr_q == '0);
					end
				end
			end
		end
	end

	// hold payload: held word, pending dispatch, result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= target_id;
			typ_q <= msg_type;
			any_q <= any_type;
			hnd_q <= message_handle;
			due_q <= due_new;
		end
		if (cmp_proc && disp) begin
			pend_q <= rd_e;
		end
		if (emit_walk || emit_fin) begin
			if (emit_fin && (op_q != FN_TICK)) begin
				out_target_q <= '0;
				out_type_q   <= '0;
				out_handle_q <= '0;
				last_q       <= 1'b0;
				case (op_q)
					FN_REMOVE: begin
						kind_q          <= KIND_REMOVE;
						removed_count_q <= removed_sat;
						found_res_q     <= 1'b0;
						rejected_full_q <= 1'b0;
						new_head_res_q  <= 1'b0;
					end
					FN_CONTAINS: begin
						kind_q          <= KIND_CONTAINS;
						removed_count_q <= '0;
						found_res_q     <= found_q;
						rejected_full_q <= 1'b0;
						new_head_res_q  <= 1'b0;
					end
					default: begin
						kind_q          <= KIND_POST;
						removed_count_q <= '0;
						found_res_q     <= 1'b0;
						rejected_full_q <= rejected_q;
						new_head_res_q  <= new_head_q;
					end
				endcase
			end else begin
				kind_q          <= KIND_DISPATCH;
				out_target_q    <= pend_q.target;
				out_type_q      <= pend_q.mtype;
				out_handle_q    <= pend_q.handle;
				removed_count_q <= '0;
				found_res_q     <= 1'b0;
				rejected_full_q <= 1'b0;
				new_head_res_q  <= 1'b0;
				last_q          <= emit_walk ? !disp : 1'b1;
			end
		end
	end

	assign valid         = valid_q;
	assign kind          = kind_q;
	assign out_target    = out_target_q;
	assign out_type      = out_type_q;
	assign out_handle    = out_handle_q;
	assign removed_count = removed_count_q;
	assign found         = found_res_q;
	assign rejected_full = rejected_full_q;
	assign new_head      = new_head_res_q;
	assign last          = last_q;

	`DEQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
	`DEQ_ASSERT_IMPLY(a_write_in_walk, ram_we, cmd.run_cmp || cmd.run_ins, "RAM write outside walk")
	`DEQ_ASSERT_NEXT(a_dispatch_limit, cmd.run_cmp && (op_q == FN_TICK), kdisp_q <= KD_W'(MAX_RESULTS), "tick dispatched too many")

endmodule

[src/delayed_event_queue_top.sv]
// ----------------------------------------------------------------------------
// Delayed event queue
// Bounded message queue in due-time order against a millisecond clock.
// ----------------------------------------------------------------------------
// A word is accepted on a rising edge with start high and busy low; busy
// stays high until its last result has been registered. Results appear on
// the result ports for one cycle each, marked by valid; the receiver cannot
// hold them off.
// Post, debounce, remove and contains give one result each; a tick gives one
// result per dispatched message (up to 16, last marks the final one) and
// none when nothing is due. Unknown function codes are taken and ignored.
// Remove, contains and tick walk all entries through the entry RAM, one per
// cycle; post walks from the tail to the insert point; debounce does both
// walks. The single RAM read port sets the walk rate.
// A dispatched message is held as the pending word and reaches the result
// ports only once the next entry shows whether it is the last, or once the
// walk ends.
// Reset empties the queue and clears the clock; RAM contents need no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delayed_event_queue_top #(
	parameter int QUEUE_DEPTH = deq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [deq_pkg::FUNC_W-1:0]         func,
	input  logic [deq_pkg::TGT_W-1:0]          target_id,
	input  logic [deq_pkg::TYPE_W-1:0]         msg_type,
	input  logic                               any_type,
	input  logic [deq_pkg::HND_W-1:0]          message_handle,
	input  logic signed [deq_pkg::DELAY_W-1:0] delay_ms,
	output logic                               valid,
	output logic [deq_pkg::KIND_W-1:0]         kind,
	output logic [deq_pkg::TGT_W-1:0]          out_target,
	output logic [deq_pkg::TYPE_W-1:0]         out_type,
	output logic [deq_pkg::HND_W-1:0]          out_handle,
	output logic [deq_pkg::RCNT_W-1:0]         removed_count,
	output logic                               found,
	output logic                               rejected_full,
	output logic                               new_head,
	output logic                               last
);

	import deq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	deq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.func           (func),
		.target_id      (target_id),
		.msg_type       (msg_type),
		.any_type       (any_type),
		.message_handle (message_handle),
		.delay_ms       (delay_ms),
		.valid          (valid),
		.kind           (kind),
		.out_target     (out_target),
		.out_type       (out_type),
		.out_handle     (out_handle),
		.removed_count  (removed_count),
		.found          (found),
		.rejected_full  (rejected_full),
		.new_head       (new_head),
		.last           (last)
	);

endmodule
